[src/sequenced_event_ring_log_defines.svh]
// ----------------------------------------------------------------------------
// sequenced_event_ring_log_defines.svh
// Assertion macros shared by the event ring log modules.
// ----------------------------------------------------------------------------
`ifndef SEQUENCED_EVENT_RING_LOG_DEFINES_SVH
`define SEQUENCED_EVENT_RING_LOG_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SERL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define SERL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/serl_pkg.sv]
// ----------------------------------------------------------------------------
// serl_pkg
// Types and constants of the sequenced event ring log.
// ----------------------------------------------------------------------------
`default_nettype none

package serl_pkg;

	localparam int SEQ_W   = 48;
	localparam int KIND_W  = 3;
	localparam int WORD_W  = 32;
	localparam int CNT_W   = 6;
	localparam int MAX_RES = 32;
	// slot field of a command, wide enough for the deepest ring (64)
	localparam int SLOT_W  = 6;

	localparam logic MODE_PUBLISH = 1'b0;
	localparam logic MODE_QUERY   = 1'b1;

	typedef logic [SEQ_W-1:0] seq_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [WORD_W-1:0] rev_before;
		logic [WORD_W-1:0] rev_after;
		logic [WORD_W-1:0] admission;
		logic [WORD_W-1:0] model_gen;
		logic [WORD_W-1:0] source_gen;
	} ev_rec_t;

	localparam int REC_W = $bits(ev_rec_t);

	typedef enum logic [1:0] {
		CMD_PUB,
		CMD_EMPTY,
		CMD_STREAM
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic               resync;
		seq_t               seq;
		logic [SLOT_W-1:0]  slot;
		logic [CNT_W-1:0]   count;
		ev_rec_t            rec;
	} cmd_t;

endpackage

`default_nettype wire

[src/serl_ram.sv]
// ----------------------------------------------------------------------------
// serl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module serl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[src/serl_queue.sv]
// ----------------------------------------------------------------------------
// serl_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sequenced_event_ring_log_defines.svh"

module serl_queue
	import serl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      valid,
	output cmd_t      head
);

	cmd_t       entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	always_comb begin
		full  = (count_q == 2'd2);
		valid = (count_q != 2'd0);
		head  = entry_q[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

	`SERL_ASSERT_IMP(a_no_push_full, clk, arst_n, full, !push, "command pushed into a full queue")

endmodule

`default_nettype wire

[src/serl_front.sv]
// ----------------------------------------------------------------------------
// serl_front
// Accepts items, keeps the ring pointers and sequence, writes published
// events and classifies queries into commands for the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sequenced_event_ring_log_defines.svh"

module serl_front
	import serl_pkg::*;
#(
	parameter int LOG_DEPTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         mode,
	input  wire logic [KIND_W-1:0]            event_kind,
	input  wire logic [WORD_W-1:0]            rev_before,
	input  wire logic [WORD_W-1:0]            rev_after,
	input  wire logic [WORD_W-1:0]            admission_count,
	input  wire logic [WORD_W-1:0]            model_gen,
	input  wire logic [WORD_W-1:0]            source_gen,
	input  wire logic [SEQ_W-1:0]             after_seq,
	input  wire logic [CNT_W-1:0]             max_count,
	input  wire logic                         q_full,
	input  wire logic                         stream_done,
	output logic                              push,
	output cmd_t                              push_cmd,
	output logic                              ram_we,
	output logic [$clog2(LOG_DEPTH)-1:0]      ram_waddr,
	output ev_rec_t                           ram_wdata
);

	localparam int AW = $clog2(LOG_DEPTH);
	localparam int FW = $clog2(LOG_DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX  = AW'(LOG_DEPTH - 1);
	localparam logic [FW-1:0] FULL_FILL = FW'(LOG_DEPTH);
	localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(LOG_DEPTH);
	localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(MAX_RES);

	seq_t          last_seq_q;
	seq_t          oldest_q;
	logic [AW-1:0] start_q;
	logic [AW-1:0] wr_ptr_q;
	logic [FW-1:0] fill_q;
	logic          stream_busy_q;

	logic             acc;
	logic             full;
	seq_t             new_seq;
	logic [SEQ_W:0]   after_inc;
	logic             too_old;
	seq_t             diff;
	logic [CNT_W-1:0] cap;
	logic [CNT_W-1:0] count;
	logic [AW-1:0]    k0;
	logic [AW:0]      slot_sum;
	logic [AW:0]      slot_wrap;
	logic [AW-1:0]    wr_next;
	logic [AW-1:0]    start_next;
	ev_rec_t          rec;

	always_comb begin
		busy = q_full | stream_busy_q;
		acc  = start & ~busy;
		full = (fill_q == FULL_FILL);

		new_seq   = last_seq_q + 1'b1;
		after_inc = {1'b0, after_seq} + 1'b1;
		too_old   = after_inc < {1'b0, oldest_q};
		diff      = last_seq_q - after_seq;

		cap   = (max_count > CAP_MAX) ? CAP_MAX : max_count;
		count = ((|diff[SEQ_W-1:CNT_W]) || (diff[CNT_W-1:0] > cap)) ? cap
			: diff[CNT_W-1:0];

		// first wanted event sits k0 places after the oldest
		k0        = after_inc[AW-1:0] - oldest_q[AW-1:0];
		slot_sum  = {1'b0, start_q} + {1'b0, k0};
		slot_wrap = (slot_sum >= DEPTH_X) ? slot_sum - DEPTH_X : slot_sum;

		wr_next    = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
		start_next = (start_q == LAST_IDX) ? '0 : start_q + 1'b1;

		rec.kind       = event_kind;
		rec.rev_before = rev_before;
		rec.rev_after  = rev_after;
		rec.admission  = admission_count;
		rec.model_gen  = model_gen;
		rec.source_gen = source_gen;

		push_cmd        = '0;
		push_cmd.kind   = CMD_EMPTY;
		if (mode == MODE_PUBLISH) begin
			push_cmd.kind = CMD_PUB;
			push_cmd.seq  = new_seq;
			push_cmd.rec  = rec;
		end else if (after_seq > last_seq_q) begin
			push_cmd.resync = 1'b1;
		end else if (after_seq == last_seq_q) begin
			push_cmd.resync = 1'b0;
		end else if (too_old) begin
			push_cmd.resync = 1'b1;
		end else if (count != '0) begin
			push_cmd.kind  = CMD_STREAM;
			push_cmd.seq   = after_inc[SEQ_W-1:0];
			push_cmd.slot  = SLOT_W'(slot_wrap[AW-1:0]);
			push_cmd.count = count;
		end

		push      = acc;
		ram_we    = acc & (mode == MODE_PUBLISH);
		ram_waddr = wr_ptr_q;
		ram_wdata = rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_q    <= '0;
			oldest_q      <= SEQ_W'(1);
			start_q       <= '0;
			wr_ptr_q      <= '0;
			fill_q        <= '0;
			stream_busy_q <= 1'b0;
		end else begin
			if (acc && (mode == MODE_PUBLISH)) begin
				last_seq_q <= new_seq;
				wr_ptr_q   <= wr_next;
				if (full) begin
					start_q  <= start_next;
					oldest_q <= oldest_q + 1'b1;
				end else begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == '0) begin
						oldest_q <= new_seq;
					end
				end
			end
			if (acc && (push_cmd.kind == CMD_STREAM)) begin
				stream_busy_q <= 1'b1;
			end else if (stream_done) begin
				stream_busy_q <= 1'b0;
			end
		end
	end

	`SERL_ASSERT_IMP(a_full_ptrs, clk, arst_n, fill_q == FULL_FILL, wr_ptr_q == start_q, "full ring with write pointer off the oldest slot")
	`SERL_ASSERT_NXT(a_pub_seq, clk, arst_n, acc && (mode == MODE_PUBLISH), last_seq_q == $past(new_seq), "publish did not advance the sequence")

endmodule

`default_nettype wire

[src/serl_back.sv]
// ----------------------------------------------------------------------------
// serl_back
// Executes commands: emits publish and empty results, streams ring reads.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sequenced_event_ring_log_defines.svh"

module serl_back
	import serl_pkg::*;
#(
	parameter int LOG_DEPTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    q_valid,
	input  cmd_t                         q_head,
	output logic                         pop,
	output logic                         stream_done,
	output logic                         ram_re,
	output logic [$clog2(LOG_DEPTH)-1:0] ram_raddr,
	input  ev_rec_t                      ram_rdata,
	output logic                         strobe,
	output logic                         has_event,
	output logic                         resync,
	output logic                         last,
	output logic [SEQ_W-1:0]             seq_out,
	output ev_rec_t                      rec_out
);

	localparam int AW = $clog2(LOG_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(LOG_DEPTH - 1);

	logic             active_q;
	logic [AW-1:0]    rd_slot_q;
	logic [CNT_W-1:0] remain_q;
	seq_t             seq_q;

	logic    valid_s1;
	logic    has_s1;
	logic    resync_s1;
	logic    last_s1;
	logic    from_ram_s1;
	seq_t    seq_s1;
	ev_rec_t rec_s1;

	logic final_rd;

	always_comb begin
		pop         = q_valid & ~active_q;
		final_rd    = (remain_q == CNT_W'(1));
		stream_done = active_q & final_rd;
		ram_re      = active_q;
		ram_raddr   = rd_slot_q;

		strobe    = valid_s1;
		has_event = has_s1;
		resync    = resync_s1;
		last      = last_s1;
		seq_out   = seq_s1;
		rec_out   = from_ram_s1 ? ram_rdata : rec_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			remain_q    <= '0;
			valid_s1    <= 1'b0;
			has_s1      <= 1'b0;
			resync_s1   <= 1'b0;
			last_s1     <= 1'b0;
			from_ram_s1 <= 1'b0;
		end else begin
			if (active_q) begin
				valid_s1    <= 1'b1;
				has_s1      <= 1'b1;
				resync_s1   <= 1'b0;
				last_s1     <= final_rd;
				from_ram_s1 <= 1'b1;
				remain_q    <= remain_q - 1'b1;
				if (final_rd) begin
					active_q <= 1'b0;
				end
			end else if (pop) begin
				case (q_head.kind)
					CMD_PUB, CMD_EMPTY: begin
						valid_s1    <= 1'b1;
						has_s1      <= (q_head.kind == CMD_PUB);
						resync_s1   <= q_head.resync;
						last_s1     <= 1'b1;
						from_ram_s1 <= 1'b0;
					end
					CMD_STREAM: begin
						valid_s1 <= 1'b0;
						active_q <= 1'b1;
						remain_q <= q_head.count;
					end
					default: begin
						valid_s1 <= 1'b0;
						active_q <= 1'b0;
					end
				endcase
			end else begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// payload and read position
	always_ff @(posedge clk) begin
		if (active_q) begin
			seq_s1    <= seq_q;
			seq_q     <= seq_q + 1'b1;
			rd_slot_q <= (rd_slot_q == LAST_IDX) ? '0 : rd_slot_q + 1'b1;
		end else if (pop) begin
			seq_s1    <= q_head.seq;
			rec_s1    <= q_head.rec;
			seq_q     <= q_head.seq;
			rd_slot_q <= q_head.slot[AW-1:0];
		end
	end

	`SERL_ASSERT_NXT(a_stream_gapless, clk, arst_n, valid_s1 && !last_s1, valid_s1, "gap inside a query result stream")

endmodule

`default_nettype wire

[src/sequenced_event_ring_log.sv]
// ----------------------------------------------------------------------------
// sequenced_event_ring_log
// Overwriting ring-buffer event log with sequence numbers and queries.
// ----------------------------------------------------------------------------
// Input channel: an item is taken on a rising edge with start high and busy
// low. mode 0 publishes an event (stamped with the next 48-bit sequence and
// stored over the oldest slot once the ring is full); mode 1 queries the
// events whose sequence is above after_seq, at most max_count (capped at 32).
// Result channel: each result is shown for one cycle with strobe high; the
// receiver must take it then, it cannot hold results off. last marks the
// final result of an item.
// Results: a publish or a query that finds nothing gives its one result from
// the queue through the output register. A streaming query reads the ring
// slot by slot and gives one event per cycle.
// Throughput: publishes and non-streaming queries go at one item per cycle
// while busy stays low; the two-entry queue between front and back absorbs
// the skew. A streaming query holds busy until its last ring read, as the
// single RAM read port serves one slot per cycle.
// Reset: sequence, pointers and fill clear at once; ring contents are not
// cleared and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module sequenced_event_ring_log
	import serl_pkg::*;
#(
	parameter int LOG_DEPTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              mode,
	input  wire logic [KIND_W-1:0] event_kind,
	input  wire logic [WORD_W-1:0] rev_before,
	input  wire logic [WORD_W-1:0] rev_after,
	input  wire logic [WORD_W-1:0] admission_count,
	input  wire logic [WORD_W-1:0] model_gen,
	input  wire logic [WORD_W-1:0] source_gen,
	input  wire logic [SEQ_W-1:0]  after_seq,
	input  wire logic [CNT_W-1:0]  max_count,
	output logic                   strobe,
	output logic                   has_event,
	output logic                   resync,
	output logic                   last,
	output logic [SEQ_W-1:0]       seq_out,
	output logic [KIND_W-1:0]      kind_out,
	output logic [WORD_W-1:0]      rev_before_out,
	output logic [WORD_W-1:0]      rev_after_out,
	output logic [WORD_W-1:0]      admission_out,
	output logic [WORD_W-1:0]      model_gen_out,
	output logic [WORD_W-1:0]      source_gen_out
);

	localparam int AW = $clog2(LOG_DEPTH);

	// front to queue
	logic    push;
	cmd_t    push_cmd;
	logic    q_full;
	// queue to back
	logic    q_valid;
	cmd_t    q_head;
	logic    pop;
	logic    stream_done;
	// ring port
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	ev_rec_t       ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	ev_rec_t       ram_rdata;
	ev_rec_t       rec_out;

	// accept and classify; publishes land in the ring here
	serl_front #(
		.LOG_DEPTH (LOG_DEPTH)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.mode            (mode),
		.event_kind      (event_kind),
		.rev_before      (rev_before),
		.rev_after       (rev_after),
		.admission_count (admission_count),
		.model_gen       (model_gen),
		.source_gen      (source_gen),
		.after_seq       (after_seq),
		.max_count       (max_count),
		.q_full          (q_full),
		.stream_done     (stream_done),
		.push            (push),
		.push_cmd        (push_cmd),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata)
	);

	// hold commands while the back is busy
	serl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	// ring storage: one record per slot
	serl_ram #(
		.WIDTH (REC_W),
		.DEPTH (LOG_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// emit results, stream ring reads for queries
	serl_back #(
		.LOG_DEPTH (LOG_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.pop         (pop),
		.stream_done (stream_done),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.strobe      (strobe),
		.has_event   (has_event),
		.resync      (resync),
		.last        (last),
		.seq_out     (seq_out),
		.rec_out     (rec_out)
	);

	always_comb begin
		kind_out       = rec_out.kind;
		rev_before_out = rec_out.rev_before;
		rev_after_out  = rec_out.rev_after;
		admission_out  = rec_out.admission;
		model_gen_out  = rec_out.model_gen;
		source_gen_out = rec_out.source_gen;
	end

endmodule

`default_nettype wire

[test/event_log_scoreboard.sv]
// ----------------------------------------------------------------------------
// event_log_scoreboard
// Watches the item and result channels of the event ring log, predicts the
// results of every accepted item and compares them field by field.
// ----------------------------------------------------------------------------
module event_log_scoreboard
	import serl_pkg::*;
#(
	parameter int LOG_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              mode,
	input  logic [KIND_W-1:0] event_kind,
	input  logic [WORD_W-1:0] rev_before,
	input  logic [WORD_W-1:0] rev_after,
	input  logic [WORD_W-1:0] admission_count,
	input  logic [WORD_W-1:0] model_gen,
	input  logic [WORD_W-1:0] source_gen,
	input  logic [SEQ_W-1:0]  after_seq,
	input  logic [CNT_W-1:0]  max_count,
	input  logic              strobe,
	input  logic              has_event,
	input  logic              resync,
	input  logic              last,
	input  logic [SEQ_W-1:0]  seq_out,
	input  logic [KIND_W-1:0] kind_out,
	input  logic [WORD_W-1:0] rev_before_out,
	input  logic [WORD_W-1:0] rev_after_out,
	input  logic [WORD_W-1:0] admission_out,
	input  logic [WORD_W-1:0] model_gen_out,
	input  logic [WORD_W-1:0] source_gen_out,
	output int                mismatches,
	output int                outstanding,
	output int                results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic    has_event;
		logic    resync;
		logic    last;
		seq_t    seq;
		ev_rec_t rec;
	} log_result_t;

	seq_t        log_last_seq;
	int          log_head;
	int          log_fill;
	seq_t        log_seq[LOG_DEPTH];
	ev_rec_t     log_rec[LOG_DEPTH];
	log_result_t pending_records[$];

	task automatic report_field(input string field, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("MISMATCH at %0t, result %0d, %s: got %h, expected %h",
			$time, results_seen, field, got, want);
	endtask

	task automatic predict_log_results(input logic op, input ev_rec_t rec_in,
			input seq_t after, input logic [CNT_W-1:0] cnt);
		int              slot;
		int              cap;
		int              i;
		logic [SEQ_W:0]  oldest;
		log_result_t     r;
		log_result_t     batch[$];
		r = '0;
		if (op == MODE_PUBLISH) begin
			log_last_seq = log_last_seq + 1'b1;
			if (log_fill < LOG_DEPTH) begin
				slot = (log_head + log_fill) % LOG_DEPTH;
				log_fill++;
			end else begin
				slot = log_head;
				log_head = (log_head + 1) % LOG_DEPTH;
			end
			log_seq[slot] = log_last_seq;
			log_rec[slot] = rec_in;
			r.has_event = 1'b1;
			r.last = 1'b1;
			r.seq = log_last_seq;
			r.rec = rec_in;
			pending_records.push_back(r);
			return;
		end
		r.last = 1'b1;
		// ahead of the log, or exactly caught up: one empty result
		if (after > log_last_seq) begin
			r.resync = 1'b1;
			pending_records.push_back(r);
			return;
		end
		if (after == log_last_seq) begin
			pending_records.push_back(r);
			return;
		end
		// older than the oldest event still held
		oldest = (log_fill > 0) ? {1'b0, log_seq[log_head]} : {1'b0, log_last_seq} + 1'b1;
		if ({1'b0, after} + 1'b1 < oldest) begin
			r.resync = 1'b1;
			pending_records.push_back(r);
			return;
		end
		cap = (cnt > MAX_RES) ? MAX_RES : int'(cnt);
		for (i = 0; i < log_fill && batch.size() < cap; i++) begin
			slot = (log_head + i) % LOG_DEPTH;
			if (log_seq[slot] > after) begin
				r = '0;
				r.has_event = 1'b1;
				r.seq = log_seq[slot];
				r.rec = log_rec[slot];
				batch.push_back(r);
			end
		end
		if (batch.size() == 0) begin
			r = '0;
			r.last = 1'b1;
			pending_records.push_back(r);
			return;
		end
		r = batch[batch.size() - 1];
		r.last = 1'b1;
		batch[batch.size() - 1] = r;
		foreach (batch[j])
			pending_records.push_back(batch[j]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		log_result_t got;
		log_result_t want;
		ev_rec_t     rec_in;
		if (!arst_n) begin
			log_last_seq = '0;
			log_head = 0;
			log_fill = 0;
			pending_records.delete();
			mismatches = 0;
			results_seen = 0;
			outstanding <= 0;
		end else begin
			if (start === 1'b1 && busy === 1'b0) begin
				rec_in.kind = event_kind;
				rec_in.rev_before = rev_before;
				rec_in.rev_after = rev_after;
				rec_in.admission = admission_count;
				rec_in.model_gen = model_gen;
				rec_in.source_gen = source_gen;
				predict_log_results(mode, rec_in, after_seq, max_count);
			end
			if (strobe !== 1'b0) begin
				got.has_event = has_event;
				got.resync = resync;
				got.last = last;
				got.seq = seq_out;
				got.rec.kind = kind_out;
				got.rec.rev_before = rev_before_out;
				got.rec.rev_after = rev_after_out;
				got.rec.admission = admission_out;
				got.rec.model_gen = model_gen_out;
				got.rec.source_gen = source_gen_out;
				if (strobe !== 1'b1) begin
					report_field("strobe", 64'(strobe), 64'(1'b1));
				end else if (pending_records.size() == 0) begin
					report_field("unexpected result, seq", 64'(got.seq), 64'(0));
				end else begin
					want = pending_records.pop_front();
					if (got.has_event !== want.has_event)
						report_field("has_event", 64'(got.has_event), 64'(want.has_event));
					if (got.resync !== want.resync)
						report_field("resync", 64'(got.resync), 64'(want.resync));
					if (got.last !== want.last)
						report_field("last", 64'(got.last), 64'(want.last));
					if (got.seq !== want.seq)
						report_field("seq_out", 64'(got.seq), 64'(want.seq));
					if (got.rec.kind !== want.rec.kind)
						report_field("kind_out", 64'(got.rec.kind), 64'(want.rec.kind));
					if (got.rec.rev_before !== want.rec.rev_before)
						report_field("rev_before_out", 64'(got.rec.rev_before),
							64'(want.rec.rev_before));
					if (got.rec.rev_after !== want.rec.rev_after)
						report_field("rev_after_out", 64'(got.rec.rev_after),
							64'(want.rec.rev_after));
					if (got.rec.admission !== want.rec.admission)
						report_field("admission_out", 64'(got.rec.admission),
							64'(want.rec.admission));
					if (got.rec.model_gen !== want.rec.model_gen)
						report_field("model_gen_out", 64'(got.rec.model_gen),
							64'(want.rec.model_gen));
					if (got.rec.source_gen !== want.rec.source_gen)
						report_field("source_gen_out", 64'(got.rec.source_gen),
							64'(want.rec.source_gen));
				end
				results_seen++;
			end
			outstanding <= pending_records.size();
		end
	end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives publish and query items into the event ring log with random gaps
// and leaves prediction and checking to the scoreboard beside the block.
// ----------------------------------------------------------------------------
module testbench;
	import serl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 32;
	localparam int RANDOM_ITEMS = 155;
	// well above the slowest run: every item a full 32-event stream plus the
	// longest sender gap
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              mode = MODE_PUBLISH;
	logic [KIND_W-1:0] event_kind = '0;
	logic [WORD_W-1:0] rev_before = '0;
	logic [WORD_W-1:0] rev_after = '0;
	logic [WORD_W-1:0] admission_count = '0;
	logic [WORD_W-1:0] model_gen = '0;
	logic [WORD_W-1:0] source_gen = '0;
	logic [SEQ_W-1:0]  after_seq = '0;
	logic [CNT_W-1:0]  max_count = '0;

	logic              busy;
	logic              strobe;
	logic              has_event;
	logic              resync;
	logic              last;
	logic [SEQ_W-1:0]  seq_out;
	logic [KIND_W-1:0] kind_out;
	logic [WORD_W-1:0] rev_before_out;
	logic [WORD_W-1:0] rev_after_out;
	logic [WORD_W-1:0] admission_out;
	logic [WORD_W-1:0] model_gen_out;
	logic [WORD_W-1:0] source_gen_out;

	int mismatches;
	int outstanding;
	int results_seen;
	int cycle_count = 0;
	int publish_count = 0;
	int query_count = 0;
	bit sender_idles = 1'b1;

	sequenced_event_ring_log #(.LOG_DEPTH(DEPTH)) uut (
		.clk, .arst_n, .start, .busy, .mode, .event_kind, .rev_before, .rev_after,
		.admission_count, .model_gen, .source_gen, .after_seq, .max_count,
		.strobe, .has_event, .resync, .last, .seq_out, .kind_out, .rev_before_out,
		.rev_after_out, .admission_out, .model_gen_out, .source_gen_out
	);

	event_log_scoreboard #(.LOG_DEPTH(DEPTH)) scoreboard (
		.clk, .arst_n, .start, .busy, .mode, .event_kind, .rev_before, .rev_after,
		.admission_count, .model_gen, .source_gen, .after_seq, .max_count,
		.strobe, .has_event, .resync, .last, .seq_out, .kind_out, .rev_before_out,
		.rev_after_out, .admission_out, .model_gen_out, .source_gen_out,
		.mismatches, .outstanding, .results_seen
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still due", cycle_count,
				outstanding);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Hold the item on the ports from a falling edge until the block takes it.
	// A gap of zero keeps start high so items go back to back.
	task automatic send_item(input logic op, input logic [KIND_W-1:0] kind,
			input logic [WORD_W-1:0] rb, input logic [WORD_W-1:0] ra,
			input logic [WORD_W-1:0] adm, input logic [WORD_W-1:0] mg,
			input logic [WORD_W-1:0] sg, input seq_t after,
			input logic [CNT_W-1:0] cnt);
		int gap;
		gap = sender_idles ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		mode <= op;
		event_kind <= kind;
		rev_before <= rb;
		rev_after <= ra;
		admission_count <= adm;
		model_gen <= mg;
		source_gen <= sg;
		after_seq <= after;
		max_count <= cnt;
		start <= 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		if (op == MODE_PUBLISH)
			publish_count++;
		else
			query_count++;
	endtask

	// Publish fields are random words, each still driven at times to the
	// extremes of all zeros or all ones.
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic post_event(input logic [KIND_W-1:0] kind);
		send_item(MODE_PUBLISH, kind, pick_word(), pick_word(), pick_word(),
			pick_word(), pick_word(), seq_t'({$urandom, $urandom}), CNT_W'($urandom));
	endtask

	// Query fields are ignored on a publish and the other way round, so the
	// unused half is filled with noise to show it has no effect.
	task automatic query_events(input seq_t after, input logic [CNT_W-1:0] cnt);
		send_item(MODE_QUERY, KIND_W'($urandom), $urandom, $urandom, $urandom,
			$urandom, $urandom, after, cnt);
	endtask

	initial begin
		seq_t              after;
		logic [CNT_W-1:0]  cnt;
		int                lo;
		int                pick;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty log, caught up at zero and ahead of it
		query_events('0, '1);
		query_events(48'd1, 6'd4);
		query_events('1, '0);
		// extremes of every publish field
		send_item(MODE_PUBLISH, '0, '0, '0, '0, '0, '0, '1, '1);
		send_item(MODE_PUBLISH, '1, '1, '1, '1, '1, '1, '0, '0);
		// every kind encoding
		for (int k = 0; k < 8; k++)
			post_event(KIND_W'(k));
		// ten events held, sequences 1..10
		query_events('0, '0);
		query_events('0, '1);
		query_events(48'd3, 6'd2);
		query_events(48'd9, 6'd32);
		query_events(48'd10, 6'd5);
		query_events(48'd11, 6'd5);
		// back to back with no gaps at all
		sender_idles = 1'b0;
		repeat (4) post_event(KIND_W'($urandom));
		query_events(48'd12, 6'd40);
		query_events(48'd0, 6'd1);
		sender_idles = 1'b1;

		// random: mostly publishes, so the ring wraps several times and the
		// too-old case opens up; queries aim mostly at the held window
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 15 == 0)
				sender_idles = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) < 55) begin
				post_event(KIND_W'($urandom));
			end else begin
				pick = $urandom_range(0, 99);
				lo = (publish_count > DEPTH + 2) ? publish_count - DEPTH - 2 : 0;
				if (pick < 10)
					after = seq_t'({$urandom, $urandom});
				else if (pick < 15)
					after = '0;
				else if (pick < 22)
					after = seq_t'(publish_count + $urandom_range(1, 3));
				else if (pick < 30)
					after = seq_t'(publish_count);
				else
					after = seq_t'($urandom_range(lo, publish_count));
				pick = $urandom_range(0, 99);
				if (pick < 8)
					cnt = '0;
				else if (pick < 16)
					cnt = CNT_W'($urandom_range(MAX_RES + 1, 63));
				else if (pick < 40)
					cnt = CNT_W'($urandom_range(1, 4));
				else
					cnt = CNT_W'($urandom_range(1, MAX_RES));
				query_events(after, cnt);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		// drain every expected result, then give the block time to show a stray one
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d publishes and %0d queries, %0d results checked.",
			publish_count, query_count, results_seen);
		$display("Ring wrapped past %0d slots; %0d mismatches found.", DEPTH, mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
